// ----- hw/rtl/rrts_pkg.sv -----
// Shared types, constants and handshake structs for the thread slot scheduler.
// Used by rrts_ctrl, rrts_dp and round_robin_thread_slot_scheduler.
package rrts_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int SLOT_W     = 2;
  localparam int CODE_W     = 8;

  typedef logic [IDX_W-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_READY   = 2'd2
  } slot_st_t;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_YIELD = 2'd1,
    REQ_EXIT  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_NONE = 2'd2,
    STS_DONE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_SCAN,
    S_COMMIT,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CODE_W-1:0] exit_value;
  } req_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] prev_slot;
    logic              switched;
    logic [CODE_W-1:0] exit_code;
  } rsp_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic commit;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic active;
    logic start;
    logic hit;
    logic first;
    logic last;
    logic busy;
  } stat_t;

endpackage

// ----- hw/rtl/rrts_ctrl.sv -----
// Sequencing state machine for the thread slot scheduler.
// Depends on rrts_pkg; drives commands into rrts_dp.
module rrts_ctrl
  import rrts_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  assign accept = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = stat.active ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        // A start, or resuming the current slot, needs no second write.
        if (stat.hit) begin
          state_next = (stat.start || stat.first) ? S_OUT : S_COMMIT;
        end else if (stat.last) begin
          state_next = S_OUT;
        end
      end
      S_COMMIT: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      S_PREP:   cmd.prep   = 1'b1;
      S_SCAN:   cmd.scan   = 1'b1;
      S_COMMIT: cmd.commit = 1'b1;
      S_OUT:    cmd.emit   = !stat.busy;
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_prep : assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_PREP)
    else $error("accepted request did not enter the prep step");

  a_commit_after_scan : assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |-> $past(state) == S_SCAN)
    else $error("commit step not preceded by a scan hit");

  a_start_hit_out : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.hit && stat.start) |=> state == S_OUT)
    else $error("start claim did not go straight to the result");
`endif

endmodule

// ----- hw/rtl/rrts_dp.sv -----
// Datapath of the thread slot scheduler: slot table, running slot, scan
// counter and result register. Depends on rrts_pkg; commanded by rrts_ctrl.
module rrts_dp
  import rrts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  output stat_t     stat,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  localparam logic [IDX_W:0] WRAP = (IDX_W + 1)'(SLOT_COUNT);

  slot_st_t          slot_state [SLOT_COUNT];
  slot_idx_t         cur;
  req_t              req_q;
  logic [CODE_W-1:0] code_q;
  slot_idx_t         prev_q;
  slot_idx_t         k;
  slot_st_t          old_st;
  status_t           res_status;
  slot_idx_t         res_slot;
  logic              res_moved;

  logic [IDX_W:0] sum;
  slot_idx_t      idx;
  logic           is_start;
  logic           is_sched;
  logic           hit;
  logic           first;
  logic           last;

  always_comb begin
    sum = {1'b0, prev_q} + {1'b0, k};
    if (is_start) begin
      idx = k;
    end else if (sum >= WRAP) begin
      idx = IDX_W'(sum - WRAP);
    end else begin
      idx = IDX_W'(sum);
    end
  end

  assign is_start = (req_q == REQ_START);
  assign is_sched = (req_q == REQ_YIELD) || (req_q == REQ_EXIT);
  assign hit      = is_start ? (slot_state[idx] == ST_EMPTY) : (slot_state[idx] == ST_READY);
  assign first    = (k == '0);
  assign last     = (k == IDX_W'(SLOT_COUNT - 1));

  assign stat.active = is_start || is_sched;
  assign stat.start  = is_start;
  assign stat.hit    = hit;
  assign stat.first  = first;
  assign stat.last   = last;
  assign stat.busy   = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_state[i] <= (i == 0) ? ST_RUNNING : ST_EMPTY;
      end
      cur       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // An exit from a non-main slot empties it before the search.
      if (cmd.prep && req_q == REQ_EXIT && prev_q != '0) begin
        slot_state[prev_q] <= ST_EMPTY;
      end
      if (cmd.scan && hit) begin
        slot_state[idx] <= is_start ? ST_READY : ST_RUNNING;
        if (!is_start && !first) cur <= idx;
      end
      if (cmd.commit && old_st != ST_EMPTY) begin
        slot_state[prev_q] <= ST_READY;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q      <= req_t'(req.req_type);
      code_q     <= req.exit_value;
      prev_q     <= cur;
      k          <= '0;
      res_status <= STS_OK;
      res_slot   <= cur;
      res_moved  <= 1'b0;
    end
    if (cmd.scan) begin
      k <= k + IDX_W'(1);
      if (first) old_st <= slot_state[idx];
      if (hit) begin
        res_status <= STS_OK;
        res_slot   <= (is_start || !first) ? idx : prev_q;
        res_moved  <= !is_start && !first;
      end else if (last) begin
        if (is_start) begin
          res_status <= STS_FULL;
          res_slot   <= '0;
        end else if (req_q == REQ_EXIT && prev_q == '0) begin
          res_status <= STS_DONE;
          res_slot   <= '0;
        end else begin
          res_status <= STS_NONE;
          res_slot   <= prev_q;
        end
      end
    end
    if (cmd.emit) begin
      rsp.status    <= res_status;
      rsp.slot      <= SLOT_W'(res_slot);
      rsp.prev_slot <= SLOT_W'(prev_q);
      rsp.switched  <= res_moved;
      rsp.exit_code <= (res_status == STS_DONE) ? code_q : '0;
    end
  end

`ifndef ASSERT_OFF
  a_main_never_empty : assert property (@(posedge clk) disable iff (rst)
    slot_state[0] != ST_EMPTY)
    else $error("main slot became empty");

  a_switch_moves : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.switched) |-> rsp.slot != rsp.prev_slot)
    else $error("switch reported without a change of slot");

  a_done_from_main : assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STS_DONE) |-> (rsp.prev_slot == '0 && rsp.slot == '0))
    else $error("process finished reported from a non-main slot");
`endif

endmodule

// ----- hw/rtl/round_robin_thread_slot_scheduler.sv -----
// Round-robin thread slot scheduler: one response per request.
// Each start, yield or exit request walks the slot table one entry a cycle through the scan counter.
// A request passes through the prep, scan, optional commit and output steps before its response is valid.
// A new request is taken only in the idle step, after the previous response is issued (held off by any stall).
// Synchronous reset: slot 0 running, other slots empty, no response pending.
module round_robin_thread_slot_scheduler
  import rrts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  cmd_t  cmd;
  stat_t stat;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rrts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
